>>> rtl/lcs_pkg.sv
// lcs_pkg: shared types and constants for the list cursor scroll block.
// Holds payload structs, the command encoding and configuration indexes.
// No dependencies.
package lcs_pkg;

  localparam int unsigned CountW   = 16;
  localparam int unsigned RowsW    = 8;
  localparam int unsigned MsW      = 16;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned DirW     = 4;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CFG_VISIBLE_ROWS  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_REPEAT_DELAY  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_REPEAT_PERIOD = 2'd2;

  localparam logic [RowsW-1:0] VISIBLE_ROWS_RST = 8'd8;
  localparam logic [MsW-1:0]   REPEAT_DELAY_RST = 16'd400;
  localparam logic [MsW-1:0]   REPEAT_PERIOD_RST = 16'd100;

  localparam logic [DirW-1:0] DIR_UP    = 4'b0001;
  localparam logic [DirW-1:0] DIR_DOWN  = 4'b0010;
  localparam logic [DirW-1:0] DIR_LEFT  = 4'b0100;
  localparam logic [DirW-1:0] DIR_RIGHT = 4'b1000;

  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_UP    = 3'd1,
    CMD_DOWN  = 3'd2,
    CMD_LEFT  = 3'd3,
    CMD_RIGHT = 3'd4,
    CMD_SET   = 3'd5
  } cmd_e;

  typedef struct packed {
    logic              action;
    logic [DirW-1:0]   dpad;
    logic [TimeW-1:0]  now_ms;
    logic [CountW-1:0] new_count;
  } in_t;

  typedef struct packed {
    logic              moved;
    logic [CountW-1:0] cursor_index;
    logic [CountW-1:0] first_visible;
  } out_t;

  typedef struct packed {
    cmd_e              op;
    logic [CountW-1:0] count;
  } cmd_t;

  typedef struct packed {
    logic [RowsW-1:0] visible_rows;
    logic [MsW-1:0]   repeat_delay_ms;
    logic [MsW-1:0]   repeat_period_ms;
  } cfg_t;

endpackage

>>> rtl/lcs_front.sv
// lcs_front: accepts pad and set-length items and turns them into commands.
// Tracks the held direction and the auto-repeat deadline.
// Depends on lcs_pkg.
module lcs_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  lcs_pkg::in_t     in_data_i,
  input  lcs_pkg::cfg_t    cfg_i,
  output logic             cmd_valid_o,
  input  logic             cmd_ready_i,
  output lcs_pkg::cmd_t    cmd_o
);

  logic [lcs_pkg::DirW-1:0]  held_q, held_d;
  logic [lcs_pkg::TimeW-1:0] deadline_q, deadline_d;
  logic [lcs_pkg::TimeW-1:0] elapsed;
  logic [lcs_pkg::DirW-1:0]  dir;
  logic                      single;
  logic                      fire;
  logic                      accept;
  lcs_pkg::cmd_e             op;

  assign in_ready_o  = cmd_ready_i;
  assign cmd_valid_o = in_valid_i;
  assign accept      = in_valid_i && cmd_ready_i;

  assign dir     = in_data_i.dpad;
  assign single  = (dir != '0) && ((dir & (dir - 4'd1)) == '0);
  assign elapsed = in_data_i.now_ms - deadline_q;

  always_comb begin
    held_d     = held_q;
    deadline_d = deadline_q;
    fire       = 1'b0;
    if (in_data_i.action) begin
      fire = 1'b0;
    end else if (!single) begin
      held_d = '0;
    end else if (dir != held_q) begin
      held_d     = dir;
      deadline_d = in_data_i.now_ms + {16'd0, cfg_i.repeat_delay_ms};
      fire       = 1'b1;
    end else if (!elapsed[lcs_pkg::TimeW-1]) begin
      deadline_d = in_data_i.now_ms + {16'd0, cfg_i.repeat_period_ms};
      fire       = 1'b1;
    end
  end

  always_comb begin
    op = lcs_pkg::CMD_NONE;
    if (in_data_i.action) begin
      op = lcs_pkg::CMD_SET;
    end else if (fire) begin
      case (dir)
        lcs_pkg::DIR_UP:    op = lcs_pkg::CMD_UP;
        lcs_pkg::DIR_DOWN:  op = lcs_pkg::CMD_DOWN;
        lcs_pkg::DIR_LEFT:  op = lcs_pkg::CMD_LEFT;
        lcs_pkg::DIR_RIGHT: op = lcs_pkg::CMD_RIGHT;
        default:            op = lcs_pkg::CMD_NONE;
      endcase
    end
  end

  assign cmd_o.op    = op;
  assign cmd_o.count = in_data_i.new_count;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q     <= '0;
      deadline_q <= '0;
    end else if (accept) begin
      held_q     <= held_d;
      deadline_q <= deadline_d;
    end
  end

  held_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(held_q))
    else $error("held direction has more than one bit set");

endmodule

>>> rtl/lcs_fifo.sv
// lcs_fifo: short command queue between the front and back parts.
// Register-based storage with read and write pointers and a fill count.
// Depends on lcs_pkg.
module lcs_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  lcs_pkg::cmd_t push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output lcs_pkg::cmd_t pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  lcs_pkg::cmd_t   mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            push, pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue fill count exceeds depth");

  count_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue fill count did not advance on transfer in");

endmodule

>>> rtl/lcs_back.sv
// lcs_back: carries out cursor and window commands and holds the result.
// Keeps list length, cursor and window top; output register decouples the sink.
// Depends on lcs_pkg.
module lcs_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  lcs_pkg::cfg_t cfg_i,
  input  logic          cmd_valid_i,
  output logic          cmd_ready_o,
  input  lcs_pkg::cmd_t cmd_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output lcs_pkg::out_t out_data_o
);

  logic [lcs_pkg::CountW-1:0] count_q, count_d;
  logic [lcs_pkg::CountW-1:0] cur_q, cur_d;
  logic [lcs_pkg::CountW-1:0] top_q, top_d;
  logic                       out_valid_q;
  lcs_pkg::out_t              out_q;
  logic                       pop;
  logic                       idle_list;
  logic [lcs_pkg::RowsW-1:0]  vis;
  logic [lcs_pkg::CountW-1:0] vis16;
  logic [lcs_pkg::CountW-1:0] last_top;
  logic [lcs_pkg::CountW-1:0] cur_inc, cur_dec;
  logic [lcs_pkg::CountW:0]   page_cur, page_top;
  logic [lcs_pkg::CountW-1:0] page_cur_c, page_top_c;
  logic [lcs_pkg::CountW-1:0] set_cur, set_last, set_top;

  function automatic logic [lcs_pkg::CountW-1:0] track(
    input logic [lcs_pkg::CountW-1:0] cur,
    input logic [lcs_pkg::CountW-1:0] top,
    input logic [lcs_pkg::CountW-1:0] rows
  );
    logic [lcs_pkg::CountW-1:0] bottom;
    logic [lcs_pkg::CountW-1:0] res;
    bottom = top + rows;
    res    = top;
    if (cur < top) begin
      res = cur;
    end else if (cur >= bottom) begin
      res = cur - rows + 16'd1;
    end
    return res;
  endfunction

  function automatic logic [lcs_pkg::CountW-1:0] page_top_of(
    input logic [lcs_pkg::CountW-1:0] count,
    input logic [lcs_pkg::CountW-1:0] rows
  );
    return (count > rows) ? count - rows : '0;
  endfunction

  assign pop         = cmd_valid_i && cmd_ready_o;
  assign cmd_ready_o = !out_valid_q || out_ready_i;
  assign vis         = cfg_i.visible_rows;
  assign vis16       = {8'd0, vis};
  assign idle_list   = (count_q == '0) || (vis == '0);
  assign last_top    = page_top_of(count_q, vis16);
  assign cur_inc     = cur_q + 16'd1;
  assign cur_dec     = cur_q - 16'd1;

  always_comb begin
    if (cmd_i.op == lcs_pkg::CMD_RIGHT) begin
      page_cur = {1'b0, cur_q} + {1'b0, vis16};
      page_top = {1'b0, top_q} + {1'b0, vis16};
    end else begin
      page_cur = (cur_q < vis16) ? '0 : {1'b0, cur_q - vis16};
      page_top = (top_q < vis16) ? '0 : {1'b0, top_q - vis16};
    end
    page_cur_c = (page_cur >= {1'b0, count_q}) ? count_q - 16'd1
                                               : page_cur[lcs_pkg::CountW-1:0];
    page_top_c = (page_top > {1'b0, last_top}) ? last_top
                                               : page_top[lcs_pkg::CountW-1:0];
  end

  always_comb begin
    if (cur_q >= cmd_i.count) begin
      set_cur = (cmd_i.count != '0) ? cmd_i.count - 16'd1 : '0;
    end else begin
      set_cur = cur_q;
    end
    set_last = page_top_of(cmd_i.count, vis16);
    set_top  = (top_q > set_last) ? set_last : top_q;
  end

  always_comb begin
    count_d = count_q;
    cur_d   = cur_q;
    top_d   = top_q;
    case (cmd_i.op)
      lcs_pkg::CMD_SET: begin
        count_d = cmd_i.count;
        cur_d   = set_cur;
        if (vis != '0) begin
          top_d = track(set_cur, set_top, vis16);
        end
      end
      lcs_pkg::CMD_DOWN: begin
        if (!idle_list) begin
          if (cur_inc >= count_q) begin
            cur_d = '0;
            top_d = '0;
          end else begin
            cur_d = cur_inc;
            top_d = track(cur_inc, top_q, vis16);
          end
        end
      end
      lcs_pkg::CMD_UP: begin
        if (!idle_list) begin
          if (cur_q == '0) begin
            cur_d = count_q - 16'd1;
            top_d = last_top;
          end else begin
            cur_d = cur_dec;
            top_d = track(cur_dec, top_q, vis16);
          end
        end
      end
      lcs_pkg::CMD_LEFT, lcs_pkg::CMD_RIGHT: begin
        if (!idle_list) begin
          cur_d = page_cur_c;
          top_d = track(page_cur_c, page_top_c, vis16);
        end
      end
      default: begin
        cur_d = cur_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      cur_q       <= '0;
      top_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        count_q     <= count_d;
        cur_q       <= cur_d;
        top_q       <= top_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_q.moved         <= (cur_d != cur_q);
      out_q.cursor_index  <= cur_d;
      out_q.first_visible <= top_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  cursor_in_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) ? (cur_q == '0) : (cur_q < count_q))
    else $error("cursor outside the list");

endmodule

>>> rtl/list_cursor_scroll_with_key_repeat.sv
// list_cursor_scroll_with_key_repeat: menu cursor and window engine with key repeat.
// Latency: an item passes through the command queue and then the output register
// before its result is valid.
// Throughput: one item per cycle while the output is not stalled; the command queue
// and output register let input and output stall independently.
// Reset: state, held direction and deadline clear to zero; registers take defaults.
// Depends on lcs_pkg, lcs_front, lcs_fifo and lcs_back.
module list_cursor_scroll_with_key_repeat #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  lcs_pkg::in_t                   in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output lcs_pkg::out_t                  out_data_o,
  input  logic                           cfg_we_i,
  input  logic [lcs_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [lcs_pkg::CfgDataW-1:0]   cfg_wdata_i
);

  lcs_pkg::cfg_t cfg_q;
  logic          push_valid, push_ready;
  lcs_pkg::cmd_t push_cmd;
  logic          pop_valid, pop_ready;
  lcs_pkg::cmd_t pop_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.visible_rows     <= lcs_pkg::VISIBLE_ROWS_RST;
      cfg_q.repeat_delay_ms  <= lcs_pkg::REPEAT_DELAY_RST;
      cfg_q.repeat_period_ms <= lcs_pkg::REPEAT_PERIOD_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lcs_pkg::CFG_VISIBLE_ROWS:  cfg_q.visible_rows     <= cfg_wdata_i[lcs_pkg::RowsW-1:0];
        lcs_pkg::CFG_REPEAT_DELAY:  cfg_q.repeat_delay_ms  <= cfg_wdata_i;
        lcs_pkg::CFG_REPEAT_PERIOD: cfg_q.repeat_period_ms <= cfg_wdata_i;
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  lcs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cfg_i       (cfg_q),
    .cmd_valid_o (push_valid),
    .cmd_ready_i (push_ready),
    .cmd_o       (push_cmd)
  );

  lcs_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_cmd)
  );

  lcs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (pop_valid),
    .cmd_ready_o (pop_ready),
    .cmd_i       (pop_cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
